// ===== rtl/rsme_pkg.sv =====
// rsme_pkg: shared types, opcode codes and sizes for the register machine executor
// no dependencies
`default_nettype none
package rsme_pkg;

  localparam int WORD_BITS        = 32;
  localparam int REG_COUNT        = 16;
  localparam int REG_IDX_BITS     = 4;
  localparam int FLAG_REG_INDEX   = 15;
  localparam int DATA_STACK_DEPTH = 256;
  localparam int CALL_STACK_DEPTH = 256;
  localparam int STK_IDX_BITS     = 8;
  localparam int STK_CNT_BITS     = 9;
  localparam int PC_BITS          = 16;
  localparam int PLEN_BITS        = 17;

  // opcodes
  localparam logic [5:0] OP_NIL  = 6'd0;
  localparam logic [5:0] OP_MV   = 6'd1;
  localparam logic [5:0] OP_ADD  = 6'd2;
  localparam logic [5:0] OP_SUB  = 6'd3;
  localparam logic [5:0] OP_MUL  = 6'd4;
  localparam logic [5:0] OP_DIV  = 6'd5;
  localparam logic [5:0] OP_MOD  = 6'd6;
  localparam logic [5:0] OP_CMP  = 6'd7;
  localparam logic [5:0] OP_JA   = 6'd8;
  localparam logic [5:0] OP_JZ   = 6'd9;
  localparam logic [5:0] OP_JL   = 6'd10;
  localparam logic [5:0] OP_JG   = 6'd11;
  localparam logic [5:0] OP_JNZ  = 6'd12;
  localparam logic [5:0] OP_JGE  = 6'd13;
  localparam logic [5:0] OP_JLE  = 6'd14;
  localparam logic [5:0] OP_PRN  = 6'd15;
  localparam logic [5:0] OP_JB   = 6'd16;
  localparam logic [5:0] OP_GB   = 6'd17;
  localparam logic [5:0] OP_SWP  = 6'd18;
  localparam logic [5:0] OP_SHR  = 6'd19;
  localparam logic [5:0] OP_SHL  = 6'd20;
  localparam logic [5:0] OP_AND  = 6'd21;
  localparam logic [5:0] OP_XOR  = 6'd22;
  localparam logic [5:0] OP_OR   = 6'd23;
  localparam logic [5:0] OP_NOT  = 6'd24;
  localparam logic [5:0] OP_INC  = 6'd25;
  localparam logic [5:0] OP_DEC  = 6'd26;
  localparam logic [5:0] OP_HLT  = 6'd27;
  localparam logic [5:0] OP_PSH  = 6'd28;
  localparam logic [5:0] OP_POP  = 6'd29;
  localparam logic [5:0] OP_BSR  = 6'd30;
  localparam logic [5:0] OP_NAND = 6'd31;
  localparam logic [5:0] OP_NXOR = 6'd32;
  localparam logic [5:0] OP_NOR  = 6'd33;
  localparam logic [5:0] OP_SN   = 6'd34;

  // error codes
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_DIV0  = 2'd1;
  localparam logic [1:0] ERR_STACK = 2'd2;
  localparam logic [1:0] ERR_OPC   = 2'd3;

  typedef struct packed {
    logic [5:0]           func;
    logic                 arg0_is_reg;
    logic [31:0]          arg0_value;
    logic                 arg1_is_reg;
    logic [31:0]          arg1_value;
    logic [31:0]          read_number;
  } in_word_t;

  typedef struct packed {
    logic [PC_BITS-1:0]   next_pc;
    logic                 done_res;
    logic                 print_valid;
    logic [31:0]          print_value;
    logic                 halted;
    logic [31:0]          exit_code;
    logic [1:0]           error;
  } out_word_t;

  // divider handshake
  typedef struct packed {
    logic                 start;
    logic [WORD_BITS-1:0] dividend;
    logic [WORD_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [WORD_BITS-1:0] quotient;
    logic [WORD_BITS-1:0] remainder;
  } div_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/rsme_div.sv =====
// rsme_div: restoring divider, one quotient bit per cycle
// depends on rsme_pkg
`default_nettype none
module rsme_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rsme_pkg::div_req_t req,
  output rsme_pkg::div_rsp_t      rsp
);
  import rsme_pkg::*;

  localparam int CNT_BITS = $clog2(WORD_BITS + 1);

  logic [WORD_BITS-1:0] quo_r, quo_nxt;
  logic [WORD_BITS-1:0] rem_r, rem_nxt;
  logic [WORD_BITS-1:0] dsr_r, dsr_nxt;
  logic [CNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [WORD_BITS:0]   trial;
  logic [WORD_BITS:0]   diff;

  // load on start, else one shift-subtract step while busy
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[WORD_BITS-1]};
    diff     = trial - {1'b0, dsr_r};
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
      cnt_nxt  = CNT_BITS'(WORD_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[WORD_BITS]) begin
        rem_nxt = diff[WORD_BITS-1:0];
        quo_nxt = {quo_r[WORD_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = trial[WORD_BITS-1:0];
        quo_nxt = {quo_r[WORD_BITS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

  // done pulses only at the end of a run
  assert property (@(posedge clk) disable iff (!rst_n) done_r |-> !busy_r)
    else $error("divider done while busy");
  assert property (@(posedge clk) disable iff (!rst_n) req.start |=> busy_r)
    else $error("divider did not start");
  assert property (@(posedge clk) disable iff (!rst_n) done_r |=> !done_r)
    else $error("divider done held");

endmodule
`default_nettype wire

// ===== rtl/register_stack_machine_execute.sv =====
// register_stack_machine_execute: executes one register-machine instruction per input word
// sequence: idle, read, exec, out; div and mod also pass the divider state (one bit per cycle)
// throughput: one word at a time; in_ready is low until the result word is taken
// the divider and the registered stack reads set this sequence
// reset: registers, pc, stack depths and program length clear; stack contents stay undefined
// depends on rsme_pkg and rsme_div
`default_nettype none
module register_stack_machine_execute (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire rsme_pkg::in_word_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output rsme_pkg::out_word_t       out_data,
  input  wire logic                 cfg_we,
  input  wire logic [16:0]          cfg_wdata
);
  import rsme_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_EXEC = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]              state_r, state_nxt;
  in_word_t                ins_r;
  logic [WORD_BITS-1:0]    regs_r [REG_COUNT];
  logic [PC_BITS-1:0]      pc_r;
  logic [STK_CNT_BITS-1:0] rdepth_r, ddepth_r;
  logic [PLEN_BITS-1:0]    plen_r;
  out_word_t               res_r;
  logic [PC_BITS-1:0]      rstk_mem [CALL_STACK_DEPTH];
  logic [WORD_BITS-1:0]    dstk_mem [DATA_STACK_DEPTH];
  logic [PC_BITS-1:0]      rstk_q_r;
  logic [WORD_BITS-1:0]    dstk_q_r;
  div_req_t                dreq;
  div_rsp_t                drsp;

  // operand decode
  logic                    v0_ok, v1_ok;
  logic [REG_IDX_BITS-1:0] i0, i1;
  logic [WORD_BITS-1:0]    ra, rb, a, b, fl;
  logic [PC_BITS-1:0]      pc_inc;

  assign v0_ok = (ins_r.arg0_value < 32'(REG_COUNT));
  assign v1_ok = (ins_r.arg1_value < 32'(REG_COUNT));
  assign i0 = ins_r.arg0_value[REG_IDX_BITS-1:0];
  assign i1 = ins_r.arg1_value[REG_IDX_BITS-1:0];
  assign ra = v0_ok ? regs_r[i0] : '0;
  assign rb = v1_ok ? regs_r[i1] : '0;
  assign a  = ins_r.arg0_is_reg ? ra : ins_r.arg0_value;
  assign b  = ins_r.arg1_is_reg ? rb : ins_r.arg1_value;
  assign fl = regs_r[REG_IDX_BITS'(FLAG_REG_INDEX)];
  assign pc_inc = pc_r + 1'b1;

  // bit scan reverse over b
  logic [4:0] bsr_idx;
  always_comb begin
    bsr_idx = '0;
    for (int i = 1; i < WORD_BITS; i++) begin
      if (b[i]) bsr_idx = 5'(i);
    end
  end

  // stack memories: read registered, address is top entry
  always_ff @(posedge clk) begin
    rstk_q_r <= rstk_mem[rdepth_r[STK_IDX_BITS-1:0] - 1'b1];
    dstk_q_r <= dstk_mem[ddepth_r[STK_IDX_BITS-1:0] - 1'b1];
    if (state_r == ST_EXEC && ins_r.func == OP_JB && rdepth_r < STK_CNT_BITS'(CALL_STACK_DEPTH))
      rstk_mem[rdepth_r[STK_IDX_BITS-1:0]] <= pc_inc;
    if (state_r == ST_EXEC && ins_r.func == OP_PSH
        && ddepth_r < STK_CNT_BITS'(DATA_STACK_DEPTH))
      dstk_mem[ddepth_r[STK_IDX_BITS-1:0]] <= a;
  end

  // shared divider
  assign dreq.start    = (state_r == ST_EXEC) && ins_r.arg0_is_reg && (b != '0)
                         && (ins_r.func == OP_DIV || ins_r.func == OP_MOD);
  assign dreq.dividend = ra;
  assign dreq.divisor  = b;

  rsme_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (dreq),
    .rsp  (drsp)
  );

  // execute: next architectural state and result
  logic                 wr0, wr1;
  logic [WORD_BITS-1:0] wd0;
  logic [PC_BITS-1:0]   nxt;
  out_word_t            res;
  logic                 rpush, rpop, dpush, dpop;
  logic                 jmp;
  logic [1:0]           f2;

  always_comb begin
    wr0 = 1'b0; wr1 = 1'b0; wd0 = '0;
    nxt = pc_inc;
    rpush = 1'b0; rpop = 1'b0; dpush = 1'b0; dpop = 1'b0;
    res = '0;
    f2 = fl[1:0];
    jmp = 1'b0;
    unique case (ins_r.func) inside
      OP_MV:   begin wr0 = ins_r.arg0_is_reg; wd0 = b; end
      OP_ADD:  begin wr0 = ins_r.arg0_is_reg; wd0 = ra + b; end
      OP_SUB:  begin wr0 = ins_r.arg0_is_reg; wd0 = ra - b; end
      OP_MUL:  begin wr0 = ins_r.arg0_is_reg; wd0 = WORD_BITS'(ra * b); end
      OP_DIV, OP_MOD: begin
        if (ins_r.arg0_is_reg && b == '0) res.error = ERR_DIV0;
      end
      OP_CMP: wr1 = 1'b0;
      OP_JA:  nxt = a[PC_BITS-1:0];
      OP_JZ, OP_JL, OP_JG, OP_JNZ, OP_JGE, OP_JLE: begin
        if (fl <= 32'd2) begin
          case (ins_r.func)
            OP_JZ:   jmp = (f2 == 2'd0);
            OP_JL:   jmp = (f2 == 2'd1);
            OP_JG:   jmp = (f2 == 2'd2);
            OP_JNZ:  jmp = (f2 != 2'd0);
            OP_JGE:  jmp = (f2 != 2'd1);
            default: jmp = (f2 != 2'd2);
          endcase
        end
        if (jmp) nxt = a[PC_BITS-1:0];
      end
      OP_PRN: begin res.print_valid = 1'b1; res.print_value = a; end
      OP_JB: begin
        if (rdepth_r >= STK_CNT_BITS'(CALL_STACK_DEPTH)) res.error = ERR_STACK;
        else begin rpush = 1'b1; nxt = a[PC_BITS-1:0]; end
      end
      OP_GB: begin
        if (rdepth_r == '0) res.error = ERR_STACK;
        else begin rpop = 1'b1; nxt = rstk_q_r; end
      end
      OP_SWP: begin
        wr0 = ins_r.arg0_is_reg && ins_r.arg1_is_reg; wd0 = rb;
        wr1 = wr0;
      end
      OP_SHR: begin
        wr0 = ins_r.arg0_is_reg;
        wd0 = (b >= 32'(WORD_BITS)) ? '0 : ra >> b[4:0];
      end
      OP_SHL: begin
        wr0 = ins_r.arg0_is_reg;
        wd0 = (b >= 32'(WORD_BITS)) ? '0 : ra << b[4:0];
      end
      OP_AND:  begin wr0 = ins_r.arg0_is_reg; wd0 = ra & b; end
      OP_XOR:  begin wr0 = ins_r.arg0_is_reg; wd0 = ra ^ b; end
      OP_OR:   begin wr0 = ins_r.arg0_is_reg; wd0 = ra | b; end
      OP_NOT:  begin wr0 = ins_r.arg0_is_reg; wd0 = ~ra; end
      OP_INC:  begin wr0 = ins_r.arg0_is_reg; wd0 = ra + 1'b1; end
      OP_DEC:  begin wr0 = ins_r.arg0_is_reg; wd0 = ra - 1'b1; end
      OP_HLT:  begin res.halted = 1'b1; res.exit_code = a; nxt = pc_r; end
      OP_PSH: begin
        if (ddepth_r >= STK_CNT_BITS'(DATA_STACK_DEPTH)) res.error = ERR_STACK;
        else dpush = 1'b1;
      end
      OP_POP: begin
        if (ins_r.arg0_is_reg) begin
          if (ddepth_r == '0) res.error = ERR_STACK;
          else begin dpop = 1'b1; wr0 = 1'b1; wd0 = dstk_q_r; end
        end
      end
      OP_BSR:  begin wr0 = 1'b1; wd0 = WORD_BITS'(bsr_idx); end
      OP_NAND: begin wr0 = ins_r.arg0_is_reg; wd0 = ~(ra & b); end
      OP_NXOR: begin wr0 = ins_r.arg0_is_reg; wd0 = ~(ra ^ b); end
      OP_NOR:  begin wr0 = ins_r.arg0_is_reg; wd0 = ~(ra | b); end
      OP_SN:   begin wr0 = ins_r.arg0_is_reg; wd0 = ins_r.read_number; end
      default: begin
        res.halted = 1'b1; res.exit_code = 32'd1; res.error = ERR_OPC; nxt = pc_r;
      end
    endcase
    res.next_pc  = nxt;
    res.done_res = ({1'b0, nxt} >= plen_r);
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_READ;
      ST_READ: state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = dreq.start ? ST_DIV : ST_OUT;
      ST_DIV:  if (drsp.done) state_nxt = ST_OUT;
      ST_OUT:  if (out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign out_data  = res_r;

  // state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      pc_r     <= '0;
      rdepth_r <= '0;
      ddepth_r <= '0;
      plen_r   <= '0;
      for (int i = 0; i < REG_COUNT; i++) regs_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) plen_r <= cfg_wdata;
      if (state_r == ST_EXEC) begin
        pc_r <= nxt;
        if (rpush) rdepth_r <= rdepth_r + 1'b1;
        if (rpop)  rdepth_r <= rdepth_r - 1'b1;
        if (dpush) ddepth_r <= ddepth_r + 1'b1;
        if (dpop)  ddepth_r <= ddepth_r - 1'b1;
        if (ins_r.func == OP_CMP)
          regs_r[REG_IDX_BITS'(FLAG_REG_INDEX)] <=
            (a < b) ? 32'd1 : ((a > b) ? 32'd2 : 32'd0);
        if (wr0 && v0_ok) regs_r[i0] <= wd0;
        if (wr1 && v1_ok) regs_r[i1] <= ra;
      end
      if (state_r == ST_DIV && drsp.done && v0_ok)
        regs_r[i0] <= (ins_r.func == OP_DIV) ? drsp.quotient : drsp.remainder;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) ins_r <= in_data;
    if (state_r == ST_EXEC) res_r <= res;
  end

  assert property (@(posedge clk) disable iff (!rst_n) in_ready |-> !out_valid)
    else $error("accepting while result pending");
  assert property (@(posedge clk) disable iff (!rst_n)
    rdepth_r <= STK_CNT_BITS'(CALL_STACK_DEPTH))
    else $error("call depth overrun");
  assert property (@(posedge clk) disable iff (!rst_n)
    ddepth_r <= STK_CNT_BITS'(DATA_STACK_DEPTH))
    else $error("data depth overrun");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(pc_r))
    else $error("pc moved while result held");

endmodule
`default_nettype wire

// ===== tb/sv/tb_register_stack_machine_execute.sv =====
// testbench for register_stack_machine_execute: directed table then random instruction words
// checks every result word against an in-bench model of the machine; depends on rsme_pkg
`default_nettype none
module tb_register_stack_machine_execute;
  import rsme_pkg::*;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_word_t in_data;
  logic out_valid;
  logic out_ready;
  out_word_t out_data;
  logic cfg_we;
  logic [16:0] cfg_wdata;

  register_stack_machine_execute dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // machine state as predicted
  logic [31:0] mach_regs [REG_COUNT];
  logic [15:0] mach_pc;
  logic [15:0] mach_rstack [CALL_STACK_DEPTH];
  int unsigned mach_rdepth;
  logic [31:0] mach_dstack [DATA_STACK_DEPTH];
  int unsigned mach_ddepth;
  logic [16:0] mach_plen;

  out_word_t pending_words[$];
  int mismatches;
  int sent_count;
  bit hold_off;
  bit send_done;
  longint cycle_count;

  // directed table
  typedef struct {
    in_word_t w;
    bit has_exp;
    out_word_t e;
  } row_t;
  row_t dir_rows[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] reg_get(logic [31:0] idx);
    return (idx < REG_COUNT) ? mach_regs[idx[3:0]] : 32'd0;
  endfunction

  function automatic void reg_set(logic [31:0] idx, logic [31:0] v);
    if (idx < REG_COUNT) mach_regs[idx[3:0]] = v;
  endfunction

  // execute one instruction on the model and give the result word
  function automatic out_word_t execute_instr(in_word_t w);
    out_word_t r;
    logic [31:0] a, b, d, t;
    logic [15:0] nxt;
    logic [31:0] f;
    logic [4:0] hi;
    bit take;
    r = '0;
    a = w.arg0_is_reg ? reg_get(w.arg0_value) : w.arg0_value;
    b = w.arg1_is_reg ? reg_get(w.arg1_value) : w.arg1_value;
    d = reg_get(w.arg0_value);
    nxt = mach_pc + 16'd1;
    r.error = ERR_NONE;
    case (w.func) inside
      OP_MV: if (w.arg0_is_reg) reg_set(w.arg0_value, b);
      OP_ADD: if (w.arg0_is_reg) reg_set(w.arg0_value, d + b);
      OP_SUB: if (w.arg0_is_reg) reg_set(w.arg0_value, d - b);
      OP_MUL: if (w.arg0_is_reg) reg_set(w.arg0_value, d * b);
      OP_DIV, OP_MOD: if (w.arg0_is_reg) begin
        if (b == 0) r.error = ERR_DIV0;
        else reg_set(w.arg0_value, (w.func == OP_DIV) ? d / b : d % b);
      end
      OP_CMP: reg_set(32'(FLAG_REG_INDEX), (a < b) ? 32'd1 : ((a > b) ? 32'd2 : 32'd0));
      OP_JA: nxt = a[15:0];
      OP_JZ, OP_JL, OP_JG, OP_JNZ, OP_JGE, OP_JLE: begin
        f = reg_get(32'(FLAG_REG_INDEX));
        take = 1'b0;
        if (f <= 2) begin
          case (w.func)
            OP_JZ: take = (f == 0);
            OP_JL: take = (f == 1);
            OP_JG: take = (f == 2);
            OP_JNZ: take = (f != 0);
            OP_JGE: take = (f != 1);
            default: take = (f != 2);
          endcase
        end
        if (take) nxt = a[15:0];
      end
      OP_PRN: begin
        r.print_valid = 1'b1;
        r.print_value = a;
      end
      OP_JB: begin
        if (mach_rdepth >= CALL_STACK_DEPTH) r.error = ERR_STACK;
        else begin
          mach_rstack[mach_rdepth] = nxt;
          mach_rdepth++;
          nxt = a[15:0];
        end
      end
      OP_GB: begin
        if (mach_rdepth == 0) r.error = ERR_STACK;
        else begin
          mach_rdepth--;
          nxt = mach_rstack[mach_rdepth];
        end
      end
      OP_SWP: if (w.arg0_is_reg && w.arg1_is_reg) begin
        t = reg_get(w.arg0_value);
        reg_set(w.arg0_value, reg_get(w.arg1_value));
        reg_set(w.arg1_value, t);
      end
      OP_SHR: if (w.arg0_is_reg) reg_set(w.arg0_value, (b >= 32) ? 32'd0 : d >> b);
      OP_SHL: if (w.arg0_is_reg) reg_set(w.arg0_value, (b >= 32) ? 32'd0 : d << b);
      OP_AND: if (w.arg0_is_reg) reg_set(w.arg0_value, d & b);
      OP_XOR: if (w.arg0_is_reg) reg_set(w.arg0_value, d ^ b);
      OP_OR: if (w.arg0_is_reg) reg_set(w.arg0_value, d | b);
      OP_NOT: if (w.arg0_is_reg) reg_set(w.arg0_value, ~d);
      OP_INC: if (w.arg0_is_reg) reg_set(w.arg0_value, d + 32'd1);
      OP_DEC: if (w.arg0_is_reg) reg_set(w.arg0_value, d - 32'd1);
      OP_HLT: begin
        r.halted = 1'b1;
        r.exit_code = a;
        nxt = mach_pc;
      end
      OP_PSH: begin
        if (mach_ddepth >= DATA_STACK_DEPTH) r.error = ERR_STACK;
        else begin
          mach_dstack[mach_ddepth] = a;
          mach_ddepth++;
        end
      end
      OP_POP: if (w.arg0_is_reg) begin
        if (mach_ddepth == 0) r.error = ERR_STACK;
        else begin
          mach_ddepth--;
          reg_set(w.arg0_value, mach_dstack[mach_ddepth]);
        end
      end
      OP_BSR: begin
        hi = 5'd0;
        for (int i = 31; i > 0; i--) begin
          if (b[i] && hi == 0) hi = i[4:0];
        end
        reg_set(w.arg0_value, {27'd0, hi});
      end
      OP_NAND: if (w.arg0_is_reg) reg_set(w.arg0_value, ~(d & b));
      OP_NXOR: if (w.arg0_is_reg) reg_set(w.arg0_value, ~(d ^ b));
      OP_NOR: if (w.arg0_is_reg) reg_set(w.arg0_value, ~(d | b));
      OP_SN: if (w.arg0_is_reg) reg_set(w.arg0_value, w.read_number);
      default: begin
        r.halted = 1'b1;
        r.exit_code = 32'd1;
        r.error = ERR_OPC;
        nxt = mach_pc;
      end
    endcase
    mach_pc = nxt;
    r.next_pc = nxt;
    r.done_res = ({1'b0, nxt} >= mach_plen);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycle_count);
    mismatches++;
  endtask

  // register index: mostly in range, sometimes out of range
  function automatic logic [31:0] pick_reg();
    case ($urandom_range(0, 15))
      0: return $urandom();
      1: return REG_COUNT + $urandom_range(0, 3);
      default: return $urandom_range(0, REG_COUNT - 1);
    endcase
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'hffff_ffff;
      2: return $urandom_range(0, 40);
      3: return 32'h8000_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    int k;
    w.func = 6'($urandom_range(0, 40));
    if ($urandom_range(0, 9) < 7) w.func = 6'($urandom_range(1, 34));
    w.arg0_is_reg = ($urandom_range(0, 5) != 0);
    w.arg1_is_reg = 1'($urandom_range(0, 1));
    w.arg0_value = w.arg0_is_reg ? pick_reg() : pick_value();
    w.arg1_value = w.arg1_is_reg ? pick_reg() : pick_value();
    w.read_number = $urandom();
    // jump targets kept near the program so done toggles
    if (w.func >= OP_JA && w.func <= OP_JLE || w.func == OP_JB) begin
      k = $urandom_range(0, 3);
      if (k != 0 && !w.arg0_is_reg) w.arg0_value = $urandom_range(0, 63);
    end
    // heavy stack runs: bias towards push/pop and call/return
    k = $urandom_range(0, 9);
    if (k == 0) w.func = OP_PSH;
    else if (k == 1) begin
      w.func = OP_POP;
      w.arg0_is_reg = 1'b1;
    end else if (k == 2) w.func = OP_JB;
    else if (k == 3) w.func = OP_GB;
    return w;
  endfunction

  function automatic in_word_t mk(logic [5:0] f, bit r0, logic [31:0] v0, bit r1,
                                  logic [31:0] v1, logic [31:0] rn);
    in_word_t w;
    w.func = f;
    w.arg0_is_reg = r0;
    w.arg0_value = v0;
    w.arg1_is_reg = r1;
    w.arg1_value = v1;
    w.read_number = rn;
    return w;
  endfunction

  function automatic out_word_t ex(logic [15:0] pc, bit dn, bit hl, logic [31:0] code,
                                   logic [1:0] err);
    out_word_t e;
    e = '0;
    e.next_pc = pc;
    e.done_res = dn;
    e.halted = hl;
    e.exit_code = code;
    e.error = err;
    return e;
  endfunction

  task automatic add_row(in_word_t w, bit has, out_word_t e);
    row_t r;
    r.w = w;
    r.has_exp = has;
    r.e = e;
    dir_rows.push_back(r);
  endtask

  // drive one word, after a random gap; valid stays up when there is no gap
  task automatic send_word(in_word_t w, bit has, out_word_t e);
    out_word_t p;
    int gap;
    gap = $urandom_range(0, 4);
    if (sent_count % 200 > 150) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    p = execute_instr(w);
    if (has && p != e)
      report_mismatch("table row pc/error", 32'({p.next_pc, p.error}),
                      32'({e.next_pc, e.error}));
    pending_words.push_back(p);
    sent_count++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_plen(logic [16:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    mach_plen = v;
  endtask

  // result checking
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected word pc", 32'(out_data.next_pc), 32'd0);
      end else begin
        want = pending_words.pop_front();
        if (out_data.next_pc !== want.next_pc)
          report_mismatch("next_pc", 32'(out_data.next_pc), 32'(want.next_pc));
        if (out_data.done_res !== want.done_res)
          report_mismatch("done_res", 32'(out_data.done_res), 32'(want.done_res));
        if (out_data.print_valid !== want.print_valid)
          report_mismatch("print_valid", 32'(out_data.print_valid), 32'(want.print_valid));
        if (out_data.print_value !== want.print_value)
          report_mismatch("print_value", out_data.print_value, want.print_value);
        if (out_data.halted !== want.halted)
          report_mismatch("halted", 32'(out_data.halted), 32'(want.halted));
        if (out_data.exit_code !== want.exit_code)
          report_mismatch("exit_code", out_data.exit_code, want.exit_code);
        if (out_data.error !== want.error)
          report_mismatch("error", 32'(out_data.error), 32'(want.error));
      end
    end
  end

  // receiver: random stalls, plus one long hold-off
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      stall = $urandom_range(0, 4);
      if (sent_count % 200 > 170) stall = 0;
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
    end
  end

  // cycle limit
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 400000) begin
        $display("FAIL register_stack_machine_execute");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    in_word_t w;
    logic [16:0] plens [4];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    mismatches = 0;
    sent_count = 0;
    hold_off = 1'b0;
    send_done = 1'b0;
    for (int i = 0; i < REG_COUNT; i++) mach_regs[i] = '0;
    mach_pc = '0;
    mach_rdepth = 0;
    mach_ddepth = 0;
    mach_plen = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: program length zero gives done on every word
    add_row(mk(OP_NIL, 0, 0, 0, 0, 0), 1, ex(16'd0, 1, 1, 32'd1, ERR_OPC));
    add_row(mk(6'd63, 0, 0, 0, 0, 0), 1, ex(16'd0, 1, 1, 32'd1, ERR_OPC));
    add_row(mk(OP_HLT, 0, 32'hffff_ffff, 0, 0, 0), 1, ex(16'd0, 1, 1, 32'hffff_ffff, ERR_NONE));
    add_row(mk(OP_GB, 0, 0, 0, 0, 0), 1, ex(16'd1, 1, 0, 0, ERR_STACK));
    add_row(mk(OP_POP, 1, 3, 0, 0, 0), 1, ex(16'd2, 1, 0, 0, ERR_STACK));
    add_row(mk(OP_POP, 0, 3, 0, 0, 0), 1, ex(16'd3, 1, 0, 0, ERR_NONE));
    add_row(mk(OP_DIV, 1, 2, 0, 0, 0), 1, ex(16'd4, 1, 0, 0, ERR_DIV0));
    add_row(mk(OP_MOD, 1, 2, 1, 9, 0), 1, ex(16'd5, 1, 0, 0, ERR_DIV0));
    add_row(mk(OP_SN, 1, 1, 0, 0, 32'hffff_ffff), 0, '0);
    add_row(mk(OP_MV, 1, 2, 0, 32'd100, 0), 0, '0);
    add_row(mk(OP_DIV, 1, 1, 1, 2, 0), 0, '0);
    add_row(mk(OP_MOD, 1, 2, 0, 32'd7, 0), 0, '0);
    add_row(mk(OP_SHL, 1, 1, 0, 32'd32, 0), 0, '0);
    add_row(mk(OP_SHR, 1, 2, 0, 32'd31, 0), 0, '0);
    add_row(mk(OP_BSR, 0, 3, 0, 32'h8000_0000, 0), 0, '0);
    add_row(mk(OP_BSR, 0, 4, 0, 0, 0), 0, '0);
    add_row(mk(OP_MV, 1, 32'(FLAG_REG_INDEX), 0, 32'd3, 0), 0, '0);
    add_row(mk(OP_JNZ, 0, 32'd9, 0, 0, 0), 0, '0);
    add_row(mk(OP_CMP, 0, 32'd1, 0, 32'd2, 0), 0, '0);
    add_row(mk(OP_JL, 0, 32'h0001_fffe, 0, 0, 0), 0, '0);
    add_row(mk(OP_JB, 0, 32'd20, 0, 0, 0), 0, '0);
    add_row(mk(OP_PRN, 1, 3, 0, 0, 0), 0, '0);
    add_row(mk(OP_GB, 0, 0, 0, 0, 0), 0, '0);
    add_row(mk(OP_SWP, 1, 1, 1, 99, 0), 0, '0);
    add_row(mk(OP_JA, 0, 32'hffff, 0, 0, 0), 0, '0);
    foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].has_exp, dir_rows[i].e);
    drain();

    // random phases over several program lengths
    plens[0] = 17'd65536;
    plens[1] = 17'd40;
    plens[2] = 17'd1;
    plens[3] = 17'($urandom_range(2, 65535));
    for (int ph = 0; ph < 5; ph++) begin
      write_plen(ph < 4 ? plens[ph] : 17'd0);
      for (int n = 0; n < 150; n++) begin
        if (ph == 1 && n == 20) hold_off = 1'b1;
        w = random_word();
        // load the stacks in one phase: calls first, then data pushes
        if (ph == 2 && n < 60) begin
          w.func = (n < 30) ? OP_JB : OP_PSH;
        end
        send_word(w, 0, '0);
      end
      drain();
    end
    // long push and call runs to reach full data and call stacks
    for (int n = 0; n < 270; n++) send_word(mk(OP_PSH, 0, $urandom(), 0, 0, 0), 0, '0);
    for (int n = 0; n < 270; n++) send_word(mk(OP_JB, 0, $urandom(), 0, 0, 0), 0, '0);
    drain();

    if (mismatches == 0) begin
      $display("PASS register_stack_machine_execute");
    end else begin
      $display("FAIL register_stack_machine_execute");
    end
    $finish;
  end

endmodule
`default_nettype wire
